[hw/rtl/sound_direction_gaussian_tracker_defines.svh]
// Assertion macros shared by the tracker RTL.
// Clock is clk, active-low synchronous reset is rst_n in every user.
`ifndef SOUND_DIRECTION_GAUSSIAN_TRACKER_DEFINES_SVH
`define SOUND_DIRECTION_GAUSSIAN_TRACKER_DEFINES_SVH

// Condition holds at every clock edge out of reset
`define SDGT_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define SDGT_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

[hw/rtl/sdgt_pkg.sv]
// Shared types, constants and rounding helpers for the direction tracker.
// No dependencies; used by sdgt_div, sdgt_mul and the top level.
`default_nettype none

package sdgt_pkg;

  localparam int MUL_AW = 33;
  localparam int MUL_BW = 25;
  localparam int MUL_PW = MUL_AW + MUL_BW;
  localparam int DIV_NW = 50;
  localparam int DIV_DW = 18;
  localparam int DIV_QW = DIV_NW + 1;

  localparam logic [16:0] WONE = 17'h10000;

  // Configuration register indexes
  localparam logic [2:0] CFG_ANGLE_SCALE = 3'd0;
  localparam logic [2:0] CFG_SMOOTH_COEF = 3'd1;
  localparam logic [2:0] CFG_CLAIM_ZONE  = 3'd2;
  localparam logic [2:0] CFG_LEARN_RATE  = 3'd3;
  localparam logic [2:0] CFG_NEW_WAIT    = 3'd4;
  localparam logic [2:0] CFG_MIN_STD     = 3'd5;
  localparam logic [2:0] CFG_MAX_STD     = 3'd6;

  typedef enum logic [4:0] {
    ST_IDLE, ST_ANG, ST_ANG_WB, ST_MED, ST_SM, ST_SM_WB,
    ST_Z2, ST_LO, ST_HI, ST_BDSQ, ST_BZV, ST_FDSQ, ST_FZV, ST_DECIDE,
    ST_AM_MUL, ST_AM_DIV, ST_AM_WAIT, ST_AV_MUL, ST_AV_DIV, ST_AV_WAIT,
    ST_AW_MUL, ST_AW, ST_NORM, ST_NB_DIV, ST_NB_WAIT, ST_NS_DIV, ST_NS_WAIT,
    ST_SWAP, ST_OUT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Divide by 2**sh, round to nearest, ties away from zero
  function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] x,
                                                  input int unsigned sh);
    logic [63:0] mag;
    logic [63:0] q;
    mag = x[63] ? 64'(-x) : 64'(x);
    q   = (mag + (64'd1 << (sh - 1))) >> sh;
    return x[63] ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [63:0] x);
    if (x > 64'sd32767) return 16'sh7fff;
    else if (x < -64'sd32768) return 16'sh8000;
    else return x[15:0];
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [63:0] x);
    if (x > 64'sd8388607) return 24'sh7fffff;
    else if (x < -64'sd8388608) return 24'sh800000;
    else return x[23:0];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/sdgt_mul.sv]
// Shared signed multiplier with a registered product.
// Depends on sdgt_pkg for operand widths.
`default_nettype none

module sdgt_mul
  import sdgt_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic signed [MUL_AW-1:0] a,
  input  wire logic signed [MUL_BW-1:0] b,
  output logic signed [MUL_PW-1:0]      prod_r
);

  // Capture a new product only when issued; hold otherwise
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= a * b;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/sdgt_div.sv]
// Iterative restoring divider, one quotient bit per cycle, rounded to nearest.
// Depends on sdgt_pkg for widths and the status struct.
`default_nettype none

module sdgt_div
  import sdgt_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic signed [DIV_NW-1:0] num,
  input  wire logic [DIV_DW-1:0]        den,
  output logic signed [DIV_QW-1:0]      quot,
  output div_stat_t                     stat
);

  logic [DIV_NW-1:0] q_r;
  logic [DIV_DW-1:0] rem_r;
  logic [DIV_DW-1:0] den_r;
  logic              neg_r;
  logic [5:0]        cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DIV_NW-1:0] mag;
  logic [DIV_DW:0]   trial;
  logic              fits;

  // Magnitude of the numerator plus half the divisor gives round-half-away
  assign mag   = (num[DIV_NW-1] ? DIV_NW'(-num) : DIV_NW'(num)) + DIV_NW'(den >> 1);
  assign trial = {rem_r, q_r[DIV_NW-1]};
  assign fits  = trial >= {1'b0, den_r};

  // Shift one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        q_r    <= mag;
        rem_r  <= '0;
        den_r  <= den;
        neg_r  <= num[DIV_NW-1];
        cnt_r  <= 6'(DIV_NW);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= fits ? DIV_DW'(trial - {1'b0, den_r}) : trial[DIV_DW-1:0];
        q_r   <= {q_r[DIV_NW-2:0], fits};
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quot      = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

`default_nettype wire

[hw/rtl/sound_direction_gaussian_tracker.sv]
// Sound direction tracker: bin to angle, median of three, IIR smoother,
// run counter and a two-Gaussian background/speaker mixture.
// Depends on sdgt_pkg, sdgt_mul, sdgt_div and the defines header.
// Usage:
//   Input channel (in_valid/in_stall) carries one frame: peak bin and a data
//   flag. Output channel (out_valid/out_stall) returns one result transaction
//   per input transaction, in order. Configuration registers are written
//   through cfg_we/cfg_index/cfg_wdata, only while the block is idle; the user
//   must keep to this, as the block does not enforce it; index 7 is ignored.
// Sequence:
//   After the accepting edge the sequencer runs the angle, median and
//   smoother steps for a frame with data only, then the mixture steps;
//   when a Gaussian claims the frame it adapts mean, variance and weight,
//   with passes through the 50-bit bit-serial divider (adapt mean, adapt
//   variance), and the two weight normalizations, when needed, pass through
//   it as well. in_stall is high until the sequencer is idle again; the sequencer state sets it.
// Reset: tracker state (but bin_r) and configuration registers return to
//   their defaults; scratch and output data registers are not reset; no clearing pass.
// Stall: a finished result waits in the output register; the next frame
//   is accepted meanwhile and its result waits until the previous one leaves.
`include "sound_direction_gaussian_tracker_defines.svh"
`default_nettype none

module sound_direction_gaussian_tracker
  import sdgt_pkg::*;
#(
  parameter int CENTER_BIN = 125
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [15:0]       cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        in_peak_bin,
  input  wire logic              in_has_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic signed [15:0]     out_beam_angle,
  output logic signed [15:0]     out_smooth_angle,
  output logic signed [15:0]     out_background_mean,
  output logic signed [15:0]     out_speaker_mean,
  output logic                   out_foreground,
  output logic signed [15:0]     out_audio_run
);

  // Configuration
  logic [15:0] scale_r, coef_r, learn_r;
  logic [11:0] cz_r;
  logic [7:0]  wait_r;
  logic [13:0] min_r, max_r;

  // Tracker state
  state_t             state_r, state_nxt;
  logic [7:0]         bin_r;
  logic signed [15:0] hist_r [3];
  logic signed [15:0] beam_r;
  logic signed [23:0] smooth_r;
  logic signed [15:0] bm_r, sm_r;
  logic [31:0]        bv_r, sv_r;
  logic [16:0]        bw_r, sw_r;
  logic [7:0]         miss_r;
  logic               fg_r;
  logic signed [15:0] run_r, run_nxt;

  // Scratch
  logic [23:0] z2_r;
  logic [27:0] lo_r, hi_r;
  logic [31:0] bdsq_r, fdsq_r;
  logic        bclaim_r;
  logic        sel_r;
  logic [17:0] sum_r;
  logic        out_valid_r;

  // Shared units
  logic                     mul_en;
  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic signed [MUL_PW-1:0] prod_r;
  logic                     div_start;
  logic signed [DIV_NW-1:0] div_num;
  logic [DIV_DW-1:0]        div_den;
  logic signed [DIV_QW-1:0] quot;
  div_stat_t                div_stat;

  // Derived values
  logic signed [9:0]  bin_diff;
  logic signed [16:0] bdev, fdev, cur_dev;
  logic signed [15:0] cur_mean;
  logic [31:0]        cur_var, cur_dsq;
  logic [16:0]        cur_w;
  logic signed [24:0] sm_diff;
  logic               fclaim;
  logic [17:0]        wsum;
  logic               load_out;
  logic signed [15:0] med;
  logic signed [63:0] vnew;
  logic [17:0]        nw;
  logic               div_wait;

  sdgt_mul u_mul (
    .clk   (clk),
    .en    (mul_en),
    .a     (mul_a),
    .b     (mul_b),
    .prod_r(prod_r)
  );

  sdgt_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .quot (quot),
    .stat (div_stat)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign load_out  = (state_r == ST_OUT) && (!out_valid_r || !out_stall);
  assign div_wait  = (state_r inside {ST_AM_WAIT, ST_AV_WAIT, ST_NB_WAIT, ST_NS_WAIT});

  assign bin_diff = $signed({2'b00, bin_r}) - $signed(10'(CENTER_BIN));
  assign bdev     = $signed({beam_r[15], beam_r}) - $signed({bm_r[15], bm_r});
  assign fdev     = $signed({beam_r[15], beam_r}) - $signed({sm_r[15], sm_r});
  assign cur_mean = sel_r ? sm_r : bm_r;
  assign cur_var  = sel_r ? sv_r : bv_r;
  assign cur_w    = sel_r ? sw_r : bw_r;
  assign cur_dsq  = sel_r ? fdsq_r : bdsq_r;
  assign cur_dev  = sel_r ? fdev : bdev;
  assign sm_diff  = $signed({smooth_r[23], smooth_r}) - $signed({beam_r[15], beam_r, 8'h00});
  assign fclaim   = (sw_r != 17'd0) && ({10'b0, fdsq_r, 16'h0000} < $unsigned(prod_r));
  assign wsum     = {1'b0, bw_r} + {1'b0, sw_r};
  assign vnew     = $signed({32'h0, cur_var}) + 64'(quot);
  assign nw       = {1'b0, cur_w} + 18'((prod_r[33:0] + 34'd32768) >> 16);

  // Median of the three most recent angles
  always_comb begin
    logic signed [15:0] a0, a1, a2;
    a0 = hist_r[0];
    a1 = hist_r[1];
    a2 = hist_r[2];
    if (a2 >= ((a0 < a1) ? a0 : a1) && a2 <= ((a0 > a1) ? a0 : a1)) begin
      med = a2;
    end else if (a1 >= ((a0 < a2) ? a0 : a2) && a1 <= ((a0 > a2) ? a0 : a2)) begin
      med = a1;
    end else begin
      med = a0;
    end
  end

  // Saturating run counter: positive with data, negative without
  always_comb begin
    logic signed [15:0] base;
    if (in_has_data) begin
      base    = (run_r > 16'sd0) ? run_r : 16'sd0;
      run_nxt = (base < 16'sd32767) ? base + 16'sd1 : base;
    end else begin
      base    = (run_r < 16'sd0) ? run_r : 16'sd0;
      run_nxt = (base > -16'sd32767) ? base - 16'sd1 : base;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (in_valid) state_nxt = in_has_data ? ST_ANG : ST_Z2;
      ST_ANG:     state_nxt = ST_ANG_WB;
      ST_ANG_WB:  state_nxt = ST_MED;
      ST_MED:     state_nxt = ST_SM;
      ST_SM:      state_nxt = ST_SM_WB;
      ST_SM_WB:   state_nxt = ST_Z2;
      ST_Z2:      state_nxt = ST_LO;
      ST_LO:      state_nxt = ST_HI;
      ST_HI:      state_nxt = ST_BDSQ;
      ST_BDSQ:    state_nxt = ST_BZV;
      ST_BZV:     state_nxt = ST_FDSQ;
      ST_FDSQ:    state_nxt = ST_FZV;
      ST_FZV:     state_nxt = ST_DECIDE;
      ST_DECIDE:  state_nxt = (bclaim_r || fclaim) ? ST_AM_MUL : ST_NORM;
      ST_AM_MUL:  state_nxt = ST_AM_DIV;
      ST_AM_DIV:  state_nxt = ST_AM_WAIT;
      ST_AM_WAIT: if (div_stat.done) state_nxt = ST_AV_MUL;
      ST_AV_MUL:  state_nxt = ST_AV_DIV;
      ST_AV_DIV:  state_nxt = ST_AV_WAIT;
      ST_AV_WAIT: if (div_stat.done) state_nxt = ST_AW_MUL;
      ST_AW_MUL:  state_nxt = ST_AW;
      ST_AW:      state_nxt = ST_NORM;
      ST_NORM:    state_nxt = (wsum != 18'd0 && wsum != {1'b0, WONE}) ? ST_NB_DIV : ST_SWAP;
      ST_NB_DIV:  state_nxt = ST_NB_WAIT;
      ST_NB_WAIT: if (div_stat.done) state_nxt = ST_NS_DIV;
      ST_NS_DIV:  state_nxt = ST_NS_WAIT;
      ST_NS_WAIT: if (div_stat.done) state_nxt = ST_SWAP;
      ST_SWAP:    state_nxt = ST_OUT;
      ST_OUT:     if (load_out) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Drive the shared multiplier and divider
  always_comb begin
    mul_en    = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state_r)
      ST_ANG: begin
        mul_en = 1'b1;
        mul_a  = $signed({17'b0, scale_r});
        mul_b  = $signed({{15{bin_diff[9]}}, bin_diff});
      end
      ST_SM: begin
        mul_en = 1'b1;
        mul_a  = $signed({17'b0, coef_r});
        mul_b  = sm_diff;
      end
      ST_Z2: begin
        mul_en = 1'b1;
        mul_a  = $signed({21'b0, cz_r});
        mul_b  = $signed({13'b0, cz_r});
      end
      ST_LO: begin
        mul_en = 1'b1;
        mul_a  = $signed({19'b0, min_r});
        mul_b  = $signed({11'b0, min_r});
      end
      ST_HI: begin
        mul_en = 1'b1;
        mul_a  = $signed({19'b0, max_r});
        mul_b  = $signed({11'b0, max_r});
      end
      ST_BDSQ: begin
        mul_en = 1'b1;
        mul_a  = $signed({{16{bdev[16]}}, bdev});
        mul_b  = $signed({{8{bdev[16]}}, bdev});
      end
      ST_BZV: begin
        mul_en = 1'b1;
        mul_a  = $signed({1'b0, bv_r});
        mul_b  = $signed({1'b0, z2_r});
      end
      ST_FDSQ: begin
        mul_en = 1'b1;
        mul_a  = $signed({{16{fdev[16]}}, fdev});
        mul_b  = $signed({{8{fdev[16]}}, fdev});
      end
      ST_FZV: begin
        mul_en = 1'b1;
        mul_a  = $signed({1'b0, sv_r});
        mul_b  = $signed({1'b0, z2_r});
      end
      ST_AM_MUL: begin
        mul_en = 1'b1;
        mul_a  = $signed({{16{cur_dev[16]}}, cur_dev});
        mul_b  = $signed({9'b0, learn_r});
      end
      ST_AV_MUL: begin
        mul_en = 1'b1;
        mul_a  = $signed({1'b0, cur_dsq}) - $signed({1'b0, cur_var});
        mul_b  = $signed({9'b0, learn_r});
      end
      ST_AW_MUL: begin
        mul_en = 1'b1;
        mul_a  = $signed({16'b0, 17'(WONE - cur_w)});
        mul_b  = $signed({9'b0, learn_r});
      end
      ST_AM_DIV, ST_AV_DIV: begin
        div_start = 1'b1;
        div_num   = prod_r[DIV_NW-1:0];
        div_den   = {1'b0, cur_w};
      end
      ST_NB_DIV: begin
        div_start = 1'b1;
        div_num   = $signed({17'b0, bw_r, 16'h0000});
        div_den   = sum_r;
      end
      ST_NS_DIV: begin
        div_start = 1'b1;
        div_num   = $signed({17'b0, sw_r, 16'h0000});
        div_den   = sum_r;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= 16'd31457;
      coef_r  <= 16'd52429;
      cz_r    <= 12'd768;
      learn_r <= 16'd1311;
      wait_r  <= 8'd5;
      min_r   <= 14'd768;
      max_r   <= 14'd2560;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ANGLE_SCALE: scale_r <= cfg_wdata;
        CFG_SMOOTH_COEF: coef_r  <= cfg_wdata;
        CFG_CLAIM_ZONE:  cz_r    <= cfg_wdata[11:0];
        CFG_LEARN_RATE:  learn_r <= cfg_wdata;
        CFG_NEW_WAIT:    wait_r  <= cfg_wdata[7:0];
        CFG_MIN_STD:     min_r   <= cfg_wdata[13:0];
        CFG_MAX_STD:     max_r   <= cfg_wdata[13:0];
        default:         ;
      endcase
    end
  end

  // Sequencer datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      hist_r   <= '{default: 16'sd0};
      beam_r   <= '0;
      smooth_r <= '0;
      bm_r     <= '0;
      sm_r     <= '0;
      bv_r     <= 32'h0001_0000;
      sv_r     <= 32'h0001_0000;
      bw_r     <= '0;
      sw_r     <= '0;
      miss_r   <= '0;
      fg_r     <= 1'b0;
      run_r    <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            bin_r <= in_peak_bin;
            run_r <= run_nxt;
          end
        end
        ST_ANG_WB: begin
          hist_r[0] <= hist_r[1];
          hist_r[1] <= hist_r[2];
          hist_r[2] <= sat16(-rnd_shr(64'(prod_r), 8));
        end
        ST_MED:    beam_r <= med;
        ST_SM_WB: begin
          smooth_r <= sat24(rnd_shr(64'(prod_r) + (64'(beam_r) <<< 24), 16));
        end
        ST_LO:     z2_r   <= prod_r[23:0];
        ST_HI:     lo_r   <= prod_r[27:0];
        ST_BDSQ:   hi_r   <= prod_r[27:0];
        ST_BZV:    bdsq_r <= prod_r[31:0];
        ST_FDSQ: begin
          bclaim_r <= (bw_r != 17'd0) && ({10'b0, bdsq_r, 16'h0000} < $unsigned(prod_r));
        end
        ST_FZV:    fdsq_r <= prod_r[31:0];
        ST_DECIDE: begin
          // Background first, then speaker, then a new speaker after the wait
          if (bclaim_r) begin
            sel_r  <= 1'b0;
            fg_r   <= 1'b0;
            miss_r <= '0;
          end else if (fclaim) begin
            sel_r  <= 1'b1;
            fg_r   <= 1'b1;
            miss_r <= '0;
          end else if (miss_r >= wait_r) begin
            sm_r   <= beam_r;
            sv_r   <= {4'b0, lo_r};
            sw_r   <= {1'b0, learn_r};
            fg_r   <= 1'b1;
            miss_r <= '0;
          end else begin
            miss_r <= miss_r + 8'd1;
          end
        end
        ST_AM_WAIT: begin
          if (div_stat.done) begin
            if (sel_r) sm_r <= sat16(64'(cur_mean) + 64'(quot));
            else       bm_r <= sat16(64'(cur_mean) + 64'(quot));
          end
        end
        ST_AV_WAIT: begin
          // Clamp low first so an inverted range ends at the upper limit
          if (div_stat.done) begin
            logic signed [63:0] v;
            v = vnew;
            if (v < $signed({36'b0, lo_r})) v = $signed({36'b0, lo_r});
            if (v > $signed({36'b0, hi_r})) v = $signed({36'b0, hi_r});
            if (sel_r) sv_r <= v[31:0];
            else       bv_r <= v[31:0];
          end
        end
        ST_AW: begin
          if (sel_r) sw_r <= (nw > {1'b0, WONE}) ? WONE : nw[16:0];
          else       bw_r <= (nw > {1'b0, WONE}) ? WONE : nw[16:0];
        end
        ST_NORM:    sum_r <= wsum;
        ST_NB_WAIT: if (div_stat.done) bw_r <= quot[16:0];
        ST_NS_WAIT: if (div_stat.done) sw_r <= quot[16:0];
        ST_SWAP: begin
          if (bw_r < sw_r) begin
            bm_r <= sm_r;
            sm_r <= bm_r;
            bv_r <= sv_r;
            sv_r <= bv_r;
            bw_r <= sw_r;
            sw_r <= bw_r;
          end
        end
        default: ;
      endcase
    end
  end

  // Output register: hold while stalled, drop after the transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_beam_angle      <= beam_r;
      out_smooth_angle    <= sat16(rnd_shr(64'(smooth_r), 8));
      out_background_mean <= bm_r;
      out_speaker_mean    <= sm_r;
      out_foreground      <= fg_r;
      out_audio_run       <= run_r;
    end
  end

  `SDGT_ASSERT_IMPLY(a_bg_dominant, state_r == ST_IDLE, bw_r >= sw_r, "background weight low")
  `SDGT_ASSERT_ALWAYS(a_weight_range, bw_r <= WONE && sw_r <= WONE, "mixture weight above one")
  `SDGT_ASSERT_IMPLY(a_div_owner, div_stat.busy, div_wait, "divider busy outside a wait state")
  `SDGT_ASSERT_ALWAYS(a_run_floor, run_r != 16'sh8000, "run counter passed its negative limit")

endmodule

`default_nettype wire
